>>> sv/lcdns_pkg.sv
// Shared types, constants and word-building functions for the character LCD nibble sequencer.
// No dependencies; every other file but lcdns_cmd_if and lcdns_word_if imports this package.
package lcdns_pkg;

	// Command codes carried on the request channel.
	typedef enum logic [2:0] {
		OP_INIT     = 3'd0,
		OP_POSITION = 3'd1,
		OP_CHAR     = 3'd2,
		OP_CLEAR    = 3'd3,
		OP_SET_MODE = 3'd4
	} opcode_t;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
	localparam int unsigned CFG_DATA_W = 7;

	localparam logic [1:0] ROW_COUNT_RESET    = 2'd2;
	localparam logic [6:0] COLUMN_COUNT_RESET = 7'd16;

	// Display row address pitch (16..64).
	localparam int unsigned ROW_PITCH = 64;

	localparam logic [7:0] CMD_ADDR    = 8'h80;
	localparam logic [7:0] CMD_CLR     = 8'h01;
	localparam logic [7:0] CMD_CONTROL = 8'h08;

	localparam logic [5:0] WAIT_SHORT = 6'd1;
	localparam logic [5:0] WAIT_LONG  = 6'd35;
	localparam logic [5:0] WAIT_INIT  = 6'd36;

	localparam logic [4:0] INIT_WORDS = 5'd21;
	// The first four nibbles of the init sequence are the slow mode-reset steps.
	localparam logic [3:0] INIT_SLOW_NIBBLES = 4'd4;

	// Work left for the serialiser by one accepted command.
	typedef struct packed {
		logic       is_init;
		logic [1:0] nbytes;
		logic       rs0;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} plan_t;

	typedef struct packed {
		logic [7:0] port_word;
		logic [5:0] wait_ms;
	} word_t;

	// Set-address command for a given row and column, truncated to a byte.
	function automatic logic [7:0] addr_cmd(input logic [1:0] row, input logic [6:0] col);
		logic [8:0] sum;
		sum = 9'(row) * 9'(ROW_PITCH) + 9'(col);
		return CMD_ADDR | sum[7:0];
	endfunction

	// Nibbles of the init sequence after the leading all-zero word:
	// three 8-bit function nibbles, the 4-bit switch, then 0x28, 0x01, 0x0C.
	function automatic logic [3:0] init_nibble(input logic [3:0] k);
		logic [3:0] nib;
		case (k)
			4'd0, 4'd1, 4'd2: nib = 4'h3;
			4'd3, 4'd4:       nib = 4'h2;
			4'd5:             nib = 4'h8;
			4'd6, 4'd8:       nib = 4'h0;
			4'd7:             nib = 4'h1;
			4'd9:             nib = 4'hC;
			default:          nib = 4'h0;
		endcase
		return nib;
	endfunction

	function automatic logic [4:0] word_count(input plan_t p);
		return p.is_init ? INIT_WORDS : {1'b0, p.nbytes, 2'b00};
	endfunction

	// Port word number idx of a plan.
	function automatic word_t build_word(input plan_t p, input logic [4:0] idx);
		word_t      w;
		logic [4:0] j;
		logic [7:0] b;
		logic [3:0] nib;
		logic       e_hi;
		logic       rs;
		j = idx - 5'd1;
		if (p.is_init) begin
			nib  = init_nibble(j[4:1]);
			e_hi = ~j[0];
			if (idx == 5'd0) begin
				w.port_word = 8'h00;
				w.wait_ms   = WAIT_LONG;
			end else begin
				w.port_word = {nib, 1'b1, e_hi, 1'b0, 1'b0};
				w.wait_ms   = (!e_hi && (j[4:1] < INIT_SLOW_NIBBLES)) ? WAIT_INIT : WAIT_SHORT;
			end
		end else begin
			// Each byte takes four words, so bit 2 of the index picks the byte.
			b    = idx[2] ? p.byte1 : p.byte0;
			rs   = idx[2] ? 1'b0 : p.rs0;
			nib  = idx[1] ? b[3:0] : b[7:4];
			e_hi = ~idx[0];
			w.port_word = {nib, 1'b1, e_hi, 1'b0, rs};
			w.wait_ms   = WAIT_SHORT;
		end
		return w;
	endfunction

endpackage

>>> sv/lcdns_cmd_if.sv
// Request channel carrying one display command.
// Depends on nothing.
interface lcdns_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [1:0] target_row;
	logic [5:0] target_column;
	logic       wrap_enable;
	logic [7:0] data_byte;

	modport source (output valid, opcode, target_row, target_column, wrap_enable, data_byte,
		input ready);
	modport sink (input valid, opcode, target_row, target_column, wrap_enable, data_byte,
		output ready);
endinterface

>>> sv/lcdns_word_if.sv
// Result channel carrying one expander port word with its wait.
// Depends on nothing.
interface lcdns_word_if;
	logic       valid;
	logic       ready;
	logic [7:0] port_word;
	logic [5:0] wait_ms;
	logic       last;

	modport source (output valid, port_word, wait_ms, last, input ready);
	modport sink (input valid, port_word, wait_ms, last, output ready);
endinterface

>>> sv/lcdns_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on lcdns_pkg for the field widths.
interface lcdns_cfg_if
	import lcdns_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/char_lcd_nibble_sequencer.sv
// A request passes the plan register, the serialiser's copy of it and the output register in turn.
// Throughput: one port word per cycle while the sink is ready, set by the serialiser's single
// output register.
// A new request is taken while the previous one is still being serialised.
// Reset (arst_n, asynchronous, active low): cursor and wrap mode cleared, row count 2,
// column count 16, no request pending and no word on the output.
module char_lcd_nibble_sequencer
	import lcdns_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lcdns_cmd_if.sink     cmd,
	lcdns_cfg_if.sink     cfg,
	lcdns_word_if.source  words
);

	// The decoder turns each request into a plan (init, or up to two bytes) and updates the
	// cursor at acceptance, so the cursor is always current for the next request. The plan
	// waits in a single register until the serialiser is free or is sending its final word.
	logic  plan_valid;
	plan_t plan;
	logic  plan_take;

	lcdns_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.plan_take  (plan_take),
		.plan_valid (plan_valid),
		.plan       (plan)
	);

	// The serialiser splits each byte into high and low nibbles, each as an E-high word then an
	// E-low word, and holds every word in its output register until the sink takes it.
	lcdns_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_valid (plan_valid),
		.plan       (plan),
		.plan_take  (plan_take),
		.words      (words)
	);

`ifndef SYNTHESIS
	// The serialiser only ever takes a plan that is actually waiting.
	a_take_needs_plan: assert property (@(posedge clk) disable iff (!arst_n)
		plan_take |-> plan_valid)
		else $error("plan taken while none was pending");

	// Requests that send nothing never reach the plan register.
	a_plan_has_words: assert property (@(posedge clk) disable iff (!arst_n)
		plan_valid |-> (plan.is_init || (plan.nbytes != 2'd0)))
		else $error("empty plan pending");

	// A waiting plan is neither lost nor overwritten before the serialiser takes it.
	a_plan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(plan_valid && !plan_take) |=> (plan_valid && $stable(plan)))
		else $error("pending plan changed before it was taken");
`endif

endmodule

>>> sv/lcdns_decode.sv
// Command decoder: configuration registers, cursor state and the plan register.
// Depends on lcdns_pkg, lcdns_cmd_if and lcdns_cfg_if.
module lcdns_decode
	import lcdns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lcdns_cmd_if.sink   cmd,
	lcdns_cfg_if.sink   cfg,
	input  logic        plan_take,
	output logic        plan_valid,
	output plan_t       plan
);

	logic [1:0] row_count_q;
	logic [6:0] column_count_q;
	logic [1:0] cursor_row_q;
	logic [6:0] cursor_column_q;
	logic       wrap_mode_q;

	logic       plan_valid_s1;
	plan_t      plan_s1;

	logic       accept;
	plan_t      plan_d;
	logic       has_words;
	logic [1:0] row_d;
	logic [6:0] col_d;
	logic       wrap_d;
	logic [6:0] col_next;
	logic       on_display;

	assign cfg.ready  = 1'b1;
	assign cmd.ready  = !plan_valid_s1 || plan_take;
	assign accept     = cmd.valid && cmd.ready;
	assign plan_valid = plan_valid_s1;
	assign plan       = plan_s1;

	always_comb begin
		plan_d     = '0;
		row_d      = cursor_row_q;
		col_d      = cursor_column_q;
		wrap_d     = wrap_mode_q;
		col_next   = cursor_column_q + 7'd1;
		on_display = 1'b0;
		unique case (cmd.opcode)
			OP_INIT: begin
				plan_d.is_init = 1'b1;
			end
			OP_POSITION: begin
				row_d      = cmd.target_row;
				col_d      = {1'b0, cmd.target_column};
				wrap_d     = cmd.wrap_enable;
				on_display = (cmd.target_row < row_count_q)
					&& ({1'b0, cmd.target_column} < column_count_q);
				if (on_display) begin
					plan_d.nbytes = 2'd1;
					plan_d.byte0  = addr_cmd(cmd.target_row, {1'b0, cmd.target_column});
				end
			end
			OP_CHAR: begin
				on_display = (cursor_row_q < row_count_q) && (cursor_column_q < column_count_q);
				if (on_display) begin
					plan_d.nbytes = 2'd1;
					plan_d.rs0    = 1'b1;
					plan_d.byte0  = cmd.data_byte;
					col_d         = col_next;
					// Running off the end of the row with wrap on moves to the next row's start.
					if ((col_next >= column_count_q) && wrap_mode_q) begin
						row_d         = cursor_row_q + 2'd1;
						col_d         = '0;
						plan_d.nbytes = 2'd2;
						plan_d.byte1  = addr_cmd(cursor_row_q + 2'd1, 7'd0);
					end
				end
			end
			OP_CLEAR: begin
				plan_d.nbytes = 2'd1;
				plan_d.byte0  = CMD_CLR;
			end
			OP_SET_MODE: begin
				plan_d.nbytes = 2'd1;
				plan_d.byte0  = CMD_CONTROL | cmd.data_byte;
			end
			default: begin
			end
		endcase
		has_words = plan_d.is_init || (plan_d.nbytes != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q     <= ROW_COUNT_RESET;
			column_count_q  <= COLUMN_COUNT_RESET;
			cursor_row_q    <= '0;
			cursor_column_q <= '0;
			wrap_mode_q     <= 1'b0;
			plan_valid_s1   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_ROW_COUNT:    row_count_q    <= cfg.data[1:0];
					CFG_COLUMN_COUNT: column_count_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				cursor_row_q    <= row_d;
				cursor_column_q <= col_d;
				wrap_mode_q     <= wrap_d;
				plan_valid_s1   <= has_words;
			end else if (plan_take) begin
				plan_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plan_s1 <= plan_d;
		end
	end

endmodule

>>> sv/lcdns_emit.sv
// Word serialiser: walks one plan into the output register, a port word per cycle while the sink is ready.
// Depends on lcdns_pkg and lcdns_word_if.
module lcdns_emit
	import lcdns_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          plan_valid,
	input  plan_t         plan,
	output logic          plan_take,
	lcdns_word_if.source  words
);

	logic       busy_q;
	plan_t      plan_q;
	logic [4:0] idx_q;
	logic [4:0] last_idx_q;

	logic       out_valid_q;
	logic [7:0] port_word_q;
	logic [5:0] wait_ms_q;
	logic       last_q;

	logic       out_free;
	logic       issue;
	logic       finishing;
	word_t      w;

	assign out_free  = !out_valid_q || words.ready;
	assign issue     = busy_q && out_free;
	assign finishing = issue && (idx_q == last_idx_q);
	assign plan_take = plan_valid && (!busy_q || finishing);
	assign w         = build_word(plan_q, idx_q);

	assign words.valid     = out_valid_q;
	assign words.port_word = port_word_q;
	assign words.wait_ms   = wait_ms_q;
	assign words.last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (plan_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + 5'd1;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (words.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_take) begin
			plan_q     <= plan;
			last_idx_q <= word_count(plan) - 5'd1;
		end
		if (issue) begin
			port_word_q <= w.port_word;
			wait_ms_q   <= w.wait_ms;
			last_q      <= finishing;
		end
	end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the character LCD nibble sequencer: display requests in, port words out.
// Depends on lcdns_pkg, the three channel interfaces and char_lcd_nibble_sequencer.
module tb;
	import lcdns_pkg::*;

	// Bits of the expander port word and the commands that the init sequence is built from.
	localparam logic [7:0] BIT_LED      = 8'h08;
	localparam logic [7:0] BIT_E        = 8'h04;
	localparam logic [7:0] FN_SET       = 8'h20;
	localparam logic [7:0] FN_EIGHT_BIT = 8'h10;
	localparam logic [7:0] FN_TWO_LINE  = 8'h08;
	localparam logic [7:0] DISPLAY_ON   = 8'h04;

	// Register indexes that the block does not decode.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int PHASES            = 9;
	localparam int PHASE_REQUESTS    = 40;
	localparam int IDLE_PERCENT      = 16;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int SETTLE_CYCLES     = 6;
	localparam int DRAIN_CYCLES      = 20;
	localparam int DRAIN_LIMIT       = 50000;
	localparam int LIMIT_CYCLES      = 400000;
	localparam int MAX_REPORTS       = 40;

	typedef struct packed {
		logic [7:0] port_word;
		logic [5:0] wait_ms;
		logic       last;
	} port_beat_t;

	// Keeps its own copy of the cursor and the display size, expands every accepted request
	// into the port words it must produce, and checks the words that come out in order.
	class port_word_tracker;
		logic [1:0] row_count;
		logic [6:0] column_count;
		logic [1:0] cursor_row;
		logic [6:0] cursor_column;
		logic       wrap_mode;
		port_beat_t pending_port_words[$];
		port_beat_t burst[$];
		int         mismatches;
		int         words_checked;

		function new();
			row_count     = ROW_COUNT_RESET;
			column_count  = COLUMN_COUNT_RESET;
			cursor_row    = '0;
			cursor_column = '0;
			wrap_mode     = 1'b0;
			mismatches    = 0;
			words_checked = 0;
		endfunction

		task report(input string what);
			if (mismatches < MAX_REPORTS)
				$display("%0t: mismatch: %s", $time, what);
			mismatches++;
		endtask

		function void emit_word(logic [7:0] word, logic [5:0] delay_ms);
			port_beat_t beat;
			beat.port_word = word;
			beat.wait_ms   = delay_ms;
			beat.last      = 1'b0;
			burst.push_back(beat);
		endfunction

		// One nibble is strobed with E high, then repeated with E low.
		function void emit_nibble(logic rs, logic [3:0] nib, logic [5:0] extra);
			logic [7:0] word;
			word = {nib, 4'h0} | BIT_LED | {7'd0, rs};
			emit_word(word | BIT_E, WAIT_SHORT);
			emit_word(word, WAIT_SHORT + extra);
		endfunction

		function void emit_byte(logic rs, logic [7:0] b);
			emit_nibble(rs, b[7:4], '0);
			emit_nibble(rs, b[3:0], '0);
		endfunction

		function void emit_address();
			int unsigned addr;
			addr = cursor_row * ROW_PITCH + cursor_column;
			emit_byte(1'b0, CMD_ADDR | 8'(addr));
		endfunction

		function bit on_display();
			return cursor_row < row_count && cursor_column < column_count;
		endfunction

		function void note_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_ROW_COUNT)
				row_count = data[1:0];
			else if (index == CFG_COLUMN_COUNT)
				column_count = data;
		endfunction

		function void note_request(logic [2:0] op, logic [1:0] row, logic [5:0] col,
				logic wen, logic [7:0] data);
			port_beat_t tail;
			logic [7:0] wake;
			burst.delete();
			wake = FN_SET | FN_EIGHT_BIT;
			case (op)
				OP_INIT: begin
					emit_word(8'h00, WAIT_LONG);
					repeat (3) emit_nibble(1'b0, wake[7:4], WAIT_LONG);
					emit_nibble(1'b0, FN_SET[7:4], WAIT_LONG);
					emit_byte(1'b0, FN_SET | FN_TWO_LINE);
					emit_byte(1'b0, CMD_CLR);
					emit_byte(1'b0, CMD_CONTROL | DISPLAY_ON);
				end
				OP_POSITION: begin
					cursor_row    = row;
					cursor_column = {1'b0, col};
					wrap_mode     = wen;
					if (on_display())
						emit_address();
				end
				OP_CHAR: begin
					if (on_display()) begin
						emit_byte(1'b1, data);
						cursor_column = cursor_column + 7'd1;
						// Wrapping moves on a row and re-addresses, whether or not that row is shown.
						if (cursor_column >= column_count && wrap_mode) begin
							cursor_row    = cursor_row + 2'd1;
							cursor_column = '0;
							emit_address();
						end
					end
				end
				OP_CLEAR:    emit_byte(1'b0, CMD_CLR);
				OP_SET_MODE: emit_byte(1'b0, CMD_CONTROL | data);
				default: ;
			endcase
			if (burst.size() > 0) begin
				tail      = burst.pop_back();
				tail.last = 1'b1;
				burst.push_back(tail);
			end
			foreach (burst[k])
				pending_port_words.push_back(burst[k]);
		endfunction

		task check_word(logic [7:0] port_word, logic [5:0] wait_ms, logic last);
			port_beat_t want;
			words_checked++;
			if (pending_port_words.size() == 0) begin
				report($sformatf("port word %02h with no request to account for it", port_word));
				return;
			end
			want = pending_port_words.pop_front();
			if (port_word !== want.port_word)
				report($sformatf("port_word %02h, wanted %02h", port_word, want.port_word));
			if (wait_ms !== want.wait_ms)
				report($sformatf("wait_ms %0d, wanted %0d (word %02h)", wait_ms, want.wait_ms,
					want.port_word));
			if (last !== want.last)
				report($sformatf("last %b, wanted %b (word %02h)", last, want.last,
					want.port_word));
		endtask
	endclass

	logic clk;
	logic arst_n;

	// The calm flag switches idling off on both sides; the long stall is asked for once.
	bit calm;
	bit long_stall_req;
	bit long_stall_done;
	int requests_sent;
	int ignored_sent;
	int settings_run;

	port_word_tracker tracker = new();

	lcdns_cmd_if  cmd_ch();
	lcdns_cfg_if  cfg_ch();
	lcdns_word_if word_ch();

	char_lcd_nibble_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.cfg    (cfg_ch),
		.words  (word_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Every port word taken by the receiver is checked at the edge at which it is accepted.
	always @(posedge clk) begin
		if (word_ch.valid && word_ch.ready)
			tracker.check_word(word_ch.port_word, word_ch.wait_ms, word_ch.last);
	end

	// The receiver drops ready at random, except in calm stretches.  Once asked, it holds off
	// for a long, counted stretch so that the block backs up and stops taking requests.
	initial begin
		word_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_stall_req && !long_stall_done) begin
				word_ch.ready = 1'b0;
				repeat (LONG_STALL_CYCLES) @(negedge clk);
				long_stall_done = 1'b1;
			end
			word_ch.ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Offers one request, starting at a falling edge, and returns at the falling edge after it
	// has been accepted.  Valid stays high from one request to the next unless a gap is drawn.
	task automatic send_request(logic [2:0] op, logic [1:0] row, logic [5:0] col, logic wen,
			logic [7:0] data);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid         = 1'b1;
		cmd_ch.opcode        = op;
		cmd_ch.target_row    = row;
		cmd_ch.target_column = col;
		cmd_ch.wrap_enable   = wen;
		cmd_ch.data_byte     = data;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		tracker.note_request(op, row, col, wen, data);
		if (op > OP_SET_MODE)
			ignored_sent++;
		else
			requests_sent++;
		@(negedge clk);
	endtask

	// Draws a request.  Most are characters after a position that lands on the display, so
	// that the cursor runs along rows and wraps; the rest are commands, stray positions, the
	// occasional init and opcodes that the block does not know.
	task automatic send_random_request();
		logic [2:0] op;
		logic [1:0] row;
		logic [5:0] col;
		logic       wen;
		logic [7:0] data;
		int         pick;
		int         span;
		row  = 2'($urandom);
		col  = 6'($urandom);
		wen  = 1'($urandom);
		data = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			op = OP_POSITION;
			if (tracker.row_count != 0 && tracker.column_count != 0) begin
				row  = 2'($urandom_range(tracker.row_count - 1));
				span = (tracker.column_count > 64) ? 64 : tracker.column_count;
				col  = 6'($urandom_range(span - 1));
			end
			wen = ($urandom_range(9) < 7);
		end else if (pick < 14)
			op = OP_POSITION;
		else if (pick < 70)
			op = OP_CHAR;
		else if (pick < 80)
			op = OP_SET_MODE;
		else if (pick < 88)
			op = OP_CLEAR;
		else if (pick < 91)
			op = OP_INIT;
		else
			op = OP_SET_MODE + 3'($urandom_range(3, 1));
		send_request(op, row, col, wen, data);
	endtask

	// Stops offering requests until every expected word has come out, then waits a few cycles
	// more so that the block is idle before anything else happens.
	task automatic settle();
		cmd_ch.valid = 1'b0;
		while (tracker.pending_port_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = index;
		cfg_ch.data  = data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		tracker.note_config(index, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// The row count register only keeps its low two bits; the rest are filled at random.
	task automatic set_display(logic [1:0] rows, logic [6:0] cols);
		settle();
		write_register(CFG_ROW_COUNT, {5'($urandom), rows});
		write_register(CFG_COLUMN_COUNT, cols);
		settings_run++;
	endtask

	// Display settings for the random phases, the extremes among them, including sizes at
	// which nothing is ever on the display.
	logic [1:0] phase_rows [PHASES] = '{2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2};
	logic [6:0] phase_cols [PHASES] = '{7'd16, 7'd127, 7'd1, 7'd64, 7'd16, 7'd20, 7'd0, 7'd40,
		7'd2};

	initial begin
		logic [2:0] op;
		int         target;
		int         guard;
		arst_n               = 1'b0;
		calm                 = 1'b1;
		long_stall_req       = 1'b0;
		long_stall_done      = 1'b0;
		requests_sent        = 0;
		ignored_sent         = 0;
		settings_run         = 1;
		cmd_ch.valid         = 1'b0;
		cmd_ch.opcode        = OP_INIT;
		cmd_ch.target_row    = '0;
		cmd_ch.target_column = '0;
		cmd_ch.wrap_enable   = 1'b0;
		cmd_ch.data_byte     = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = CFG_ROW_COUNT;
		cfg_ch.data          = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed requests at the reset size of two rows of sixteen, with no idling: init,
		// every command at the edges of its fields, and the opcodes that must be ignored.
		send_request(OP_INIT, 2'd0, 6'd0, 1'b0, 8'h00);
		send_request(OP_POSITION, 2'd0, 6'd0, 1'b1, 8'h00);
		send_request(OP_CHAR, 2'd3, 6'd63, 1'b0, 8'h00);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b1, 8'hFF);
		send_request(OP_SET_MODE, 2'd0, 6'd0, 1'b0, 8'h00);
		send_request(OP_SET_MODE, 2'd3, 6'd63, 1'b1, 8'hFF);
		send_request(OP_CLEAR, 2'd0, 6'd0, 1'b0, 8'h00);
		op = OP_SET_MODE;
		repeat (3) begin
			op++;
			send_request(op, 2'd1, 6'd5, 1'b1, 8'h3C);
		end
		// A target off the display sends nothing, and the character after it is dropped.
		send_request(OP_POSITION, 2'd3, 6'd63, 1'b0, 8'h00);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h41);
		// The last column of the last row wraps onto a row that is not shown; its address runs into
		// the command bit of the byte and must still be sent.
		send_request(OP_POSITION, 2'd1, 6'd15, 1'b1, 8'h00);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h5A);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h5B);
		// Without wrapping the cursor simply runs off the end of the row.
		send_request(OP_POSITION, 2'd0, 6'd15, 1'b0, 8'h00);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h61);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h62);

		// Writes to the undecoded indexes must leave the display size alone.
		settle();
		write_register(CFG_SPARE_LO, 7'h7F);
		write_register(CFG_SPARE_HI, 7'h00);

		// One row of sixty-four: the wrap still addresses row one although it is not shown.
		set_display(2'd1, 7'd64);
		send_request(OP_POSITION, 2'd0, 6'd63, 1'b1, 8'h00);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h7E);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h7F);
		send_request(OP_INIT, 2'd2, 6'd40, 1'b1, 8'hA5);

		// A row count of zero means nothing is ever on the display.
		set_display(2'd0, 7'd16);
		send_request(OP_POSITION, 2'd0, 6'd0, 1'b1, 8'h00);
		send_request(OP_CHAR, 2'd0, 6'd0, 1'b0, 8'h30);

		// Random phases, one per display setting.  Each starts from an idle block, which also
		// makes the sender wait for every outstanding word.  The second phase carries the long
		// receiver stall, and the fourth runs with no idling on either side.
		for (int p = 0; p < PHASES; p++) begin
			set_display(phase_rows[p], phase_cols[p]);
			calm = (p == 3);
			if (p == 1)
				long_stall_req = 1'b1;
			target = requests_sent + PHASE_REQUESTS;
			while (requests_sent < target)
				send_random_request();
		end
		cmd_ch.valid = 1'b0;

		guard = 0;
		while (tracker.pending_port_words.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.pending_port_words.size() != 0)
			tracker.report($sformatf("%0d port words never arrived",
				tracker.pending_port_words.size()));

		$display("Ran %0d requests and %0d unknown opcodes over %0d display settings.",
			requests_sent, ignored_sent, settings_run);
		$display("Checked %0d port words, with wrap, off-display and overflowing addresses.",
			tracker.words_checked);
		if (tracker.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Backstop in case the block hangs.
	initial begin
		#(LIMIT_CYCLES * 10);
		$display("Run stopped after %0d cycles without finishing.", LIMIT_CYCLES);
		$display("Mismatches found");
		$finish;
	end

endmodule
